/* src/c2d_pkg.sv */
// Shared types and constants for the 2D convolution engine.
// No dependencies; used by c2d_mac and conv2d_multichannel_engine_core.
package c2d_pkg;

  localparam int DATA_W = 16;

  // input command codes
  localparam logic [1:0] CMD_LOAD_ACT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_WGT  = 2'd1;
  localparam logic [1:0] CMD_LOAD_BIAS = 2'd2;
  localparam logic [1:0] CMD_COMPUTE   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_SATURATED = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;
  localparam logic [1:0] STAT_BAD_SHAPE = 2'd3;

  // configuration register indexes
  localparam logic [3:0] REG_IN_CHANNELS  = 4'd0;
  localparam logic [3:0] REG_IN_HEIGHT    = 4'd1;
  localparam logic [3:0] REG_IN_WIDTH     = 4'd2;
  localparam logic [3:0] REG_OUT_CHANNELS = 4'd3;
  localparam logic [3:0] REG_KERNEL_SIZE  = 4'd4;
  localparam logic [3:0] REG_STEP_SIZE    = 4'd5;
  localparam logic [3:0] REG_PAD_AMOUNT   = 4'd6;
  localparam logic [3:0] REG_BIAS_ENABLE  = 4'd7;

  localparam int STEP_MAX = 4;
  localparam int PAD_MAX  = 4;

  typedef struct packed {
    logic clear;  // zero the accumulator and flush the product stage
    logic en;     // operands on a/b are valid this cycle
  } mac_ctl_t;

endpackage

/* src/conv2d_multichannel_engine_core.sv */
// Top level of the 2D convolution engine: config registers, sequencer, stores.
// Depends on c2d_pkg, c2d_ram, c2d_mac.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------------
//  in      | in_valid / in_stall     | command, flat_index, load_value, target_channel,
//          |                         | target_row, target_col
//  out     | out_valid / out_stall   | result_value, status
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A load is written to its store on transfer. A compute walks in_channels*kernel_size^2 taps
// on the single MAC (one tap per cycle, padded taps still spend their cycle) between the check
// and setup states and the pipeline drain; a shape or coordinate error goes from check to done.
// in_stall is high from compute transfer until the result moves into the output register;
// the next item is taken while that result waits for out_stall to drop.
// Synchronous active-high reset sets config and control registers; stores are not cleared.
module conv2d_multichannel_engine_core #(
  parameter int MAX_IN_CHANNELS  = 8,
  parameter int MAX_OUT_CHANNELS = 16,
  parameter int MAX_SIDE         = 32,
  parameter int MAX_KERNEL       = 5,
  parameter int FRACTION_BITS    = 8
) (
  input  logic               clk,
  input  logic               rst,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [12:0]        flat_index,
  input  logic signed [15:0] load_value,
  input  logic [3:0]         target_channel,
  input  logic [5:0]         target_row,
  input  logic [5:0]         target_col,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] result_value,
  output logic [1:0]         status,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [5:0]         cfg_data
);

  localparam int DW = c2d_pkg::DATA_W;

  localparam int ACT_DEPTH  = MAX_IN_CHANNELS * MAX_SIDE * MAX_SIDE;
  localparam int WGT_DEPTH  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int BIAS_DEPTH = MAX_OUT_CHANNELS;
  localparam int ACT_AW  = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WGT_AW  = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int BIAS_AW = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
  localparam int ACT_IW  = $clog2(ACT_DEPTH + 1);
  localparam int WGT_IW  = $clog2(WGT_DEPTH + 1);
  localparam int ACC_W   = 2 * DW + 1 + $clog2(MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL + 2);
  localparam int ROW_W   = 18;

  localparam logic signed [DW:0] BIAS_SCALE = (DW + 1)'(1) << FRACTION_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SETUP1 = 3'd2;
  localparam logic [2:0] S_SETUP2 = 3'd3;
  localparam logic [2:0] S_SETUP3 = 3'd4;
  localparam logic [2:0] S_RUN    = 3'd5;
  localparam logic [2:0] S_DRAIN  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  // configuration registers
  logic [3:0] in_channels;
  logic [5:0] in_height;
  logic [5:0] in_width;
  logic [4:0] out_channels;
  logic [2:0] kernel_size;
  logic [2:0] step_size;
  logic [2:0] pad_amount;
  logic       bias_enable;

  logic [2:0] state;
  logic       in_xfer;

  // latched compute target
  logic [3:0] co_q;
  logic [5:0] ho_q;
  logic [5:0] wo_q;

  // setup products
  logic signed [10:0]      h0;
  logic signed [10:0]      w0;
  logic [11:0]             plane;
  logic [7:0]              wprod;
  logic [10:0]             wprod2;
  logic signed [ROW_W-1:0] row_start;

  // tap walk
  logic [3:0]              ci;
  logic [2:0]              kh;
  logic [2:0]              kw;
  logic signed [10:0]      ih;
  logic signed [10:0]      iw;
  logic signed [ROW_W-1:0] row_off;
  logic [ACT_IW-1:0]       chan_base;
  logic [WGT_IW-1:0]       widx;
  logic                    rd_ok;
  logic [1:0]              dcnt;

  logic signed [15:0] res_value;
  logic [1:0]         res_status;

  // checks
  logic       shape_bad;
  logic       coord_bad;
  logic [7:0] span_h;
  logic [7:0] span_w;
  logic [8:0] ho_step;
  logic [8:0] wo_step;
  logic       ih_ok;
  logic       iw_ok;
  logic       tap_ok;
  logic       last_kw;
  logic       last_kh;
  logic       last_ci;

  // stores and MAC
  logic [31:0]             act_sum;
  logic                    act_we;
  logic                    wgt_we;
  logic                    bias_we;
  logic [DW-1:0]           act_rdata;
  logic [DW-1:0]           wgt_rdata;
  logic [DW-1:0]           bias_rdata;
  logic                    bias_go;
  c2d_pkg::mac_ctl_t       mac_ctl;
  logic signed [DW-1:0]    mac_a;
  logic signed [DW:0]      mac_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;
  logic                    sat_hi;
  logic                    sat_lo;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_channels  <= 4'd1;
      in_height    <= 6'd32;
      in_width     <= 6'd32;
      out_channels <= 5'd1;
      kernel_size  <= 3'd3;
      step_size    <= 3'd1;
      pad_amount   <= 3'd0;
      bias_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        c2d_pkg::REG_IN_CHANNELS:  in_channels  <= cfg_data[3:0];
        c2d_pkg::REG_IN_HEIGHT:    in_height    <= cfg_data;
        c2d_pkg::REG_IN_WIDTH:     in_width     <= cfg_data;
        c2d_pkg::REG_OUT_CHANNELS: out_channels <= cfg_data[4:0];
        c2d_pkg::REG_KERNEL_SIZE:  kernel_size  <= cfg_data[2:0];
        c2d_pkg::REG_STEP_SIZE:    step_size    <= cfg_data[2:0];
        c2d_pkg::REG_PAD_AMOUNT:   pad_amount   <= cfg_data[2:0];
        c2d_pkg::REG_BIAS_ENABLE:  bias_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shape and coordinate checks; output-size compare done as ho*stride <= span
  always_comb begin
    span_h  = {2'b0, in_height} + {4'b0, pad_amount, 1'b0} - {5'b0, kernel_size};
    span_w  = {2'b0, in_width} + {4'b0, pad_amount, 1'b0} - {5'b0, kernel_size};
    ho_step = {3'b0, ho_q} * {6'b0, step_size};
    wo_step = {3'b0, wo_q} * {6'b0, step_size};
    shape_bad = (in_channels == 4'd0) || (32'(in_channels) > MAX_IN_CHANNELS) ||
                (in_height == 6'd0) || (32'(in_height) > MAX_SIDE) ||
                (in_width == 6'd0) || (32'(in_width) > MAX_SIDE) ||
                (out_channels == 5'd0) || (32'(out_channels) > MAX_OUT_CHANNELS) ||
                (kernel_size == 3'd0) || (32'(kernel_size) > MAX_KERNEL) ||
                (step_size == 3'd0) || (32'(step_size) > c2d_pkg::STEP_MAX) ||
                (32'(pad_amount) > c2d_pkg::PAD_MAX) ||
                ({5'b0, kernel_size} > {2'b0, in_height} + {4'b0, pad_amount, 1'b0}) ||
                ({5'b0, kernel_size} > {2'b0, in_width} + {4'b0, pad_amount, 1'b0});
    coord_bad = ({1'b0, co_q} >= out_channels) || (ho_step > {1'b0, span_h}) ||
                (wo_step > {1'b0, span_w});
  end

  always_comb begin
    ih_ok   = !ih[10] && (ih[9:0] < {4'b0, in_height});
    iw_ok   = !iw[10] && (iw[9:0] < {4'b0, in_width});
    tap_ok  = ih_ok && iw_ok;
    last_kw = (kw == kernel_size - 3'd1);
    last_kh = (kh == kernel_size - 3'd1);
    last_ci = (ci == in_channels - 4'd1);
    act_sum = 32'(chan_base) + 32'(row_off) + 32'(iw);
  end

  // final scaling: floor shift, then clamp to 16 bits
  always_comb begin
    shifted = acc >>> FRACTION_BITS;
    sat_hi  = !shifted[ACC_W-1] && (|shifted[ACC_W-2:DW-1]);
    sat_lo  = shifted[ACC_W-1] && !(&shifted[ACC_W-2:DW-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_ok <= 1'b0;
      dcnt  <= 2'd0;
    end else begin
      rd_ok <= (state == S_RUN) && tap_ok;
      case (state)
        S_IDLE: begin
          if (in_xfer && command == c2d_pkg::CMD_COMPUTE) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (shape_bad || coord_bad) begin
            state <= S_DONE;
          end else begin
            state <= S_SETUP1;
          end
        end
        S_SETUP1: state <= S_SETUP2;
        S_SETUP2: state <= S_SETUP3;
        S_SETUP3: state <= S_RUN;
        S_RUN: begin
          if (last_kw && last_kh && last_ci) begin
            state <= S_DRAIN;
            dcnt  <= 2'd0;
          end
        end
        S_DRAIN: begin
          dcnt <= dcnt + 2'd1;
          if (dcnt == 2'd3) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        co_q <= target_channel;
        ho_q <= target_row;
        wo_q <= target_col;
      end
      S_CHECK: begin
        res_value <= '0;
        if (shape_bad) begin
          res_status <= c2d_pkg::STAT_BAD_SHAPE;
        end else begin
          res_status <= c2d_pkg::STAT_RANGE;
        end
      end
      S_SETUP1: begin
        h0    <= $signed({2'b0, ho_step}) - $signed({8'b0, pad_amount});
        w0    <= $signed({2'b0, wo_step}) - $signed({8'b0, pad_amount});
        plane <= {6'b0, in_height} * {6'b0, in_width};
        wprod <= {4'b0, co_q} * {4'b0, in_channels};
      end
      S_SETUP2: begin
        row_start <= ROW_W'(h0) * ROW_W'($signed({1'b0, in_width}));
        wprod2    <= {3'b0, wprod} * {8'b0, kernel_size};
      end
      S_SETUP3: begin
        widx      <= WGT_IW'({3'b0, wprod2} * {11'b0, kernel_size});
        row_off   <= row_start;
        chan_base <= '0;
        ci        <= '0;
        kh        <= '0;
        kw        <= '0;
        ih        <= h0;
        iw        <= w0;
      end
      S_RUN: begin
        widx <= widx + WGT_IW'(1);
        if (!last_kw) begin
          kw <= kw + 3'd1;
          iw <= iw + 11'sd1;
        end else begin
          kw <= '0;
          iw <= w0;
          if (!last_kh) begin
            kh      <= kh + 3'd1;
            ih      <= ih + 11'sd1;
            row_off <= row_off + ROW_W'($signed({1'b0, in_width}));
          end else begin
            kh        <= '0;
            ih        <= h0;
            row_off   <= row_start;
            ci        <= ci + 4'd1;
            chan_base <= chan_base + ACT_IW'(plane);
          end
        end
      end
      S_DRAIN: begin
        if (dcnt == 2'd3) begin
          if (sat_hi) begin
            res_value  <= 16'sh7fff;
            res_status <= c2d_pkg::STAT_SATURATED;
          end else if (sat_lo) begin
            res_value  <= -16'sh8000;
            res_status <= c2d_pkg::STAT_SATURATED;
          end else begin
            res_value  <= shifted[DW-1:0];
            res_status <= c2d_pkg::STAT_OK;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      result_value <= res_value;
      status       <= res_status;
    end
  end

  // stores
  assign act_we  = in_xfer && (command == c2d_pkg::CMD_LOAD_ACT) &&
                   (32'(flat_index) < ACT_DEPTH);
  assign wgt_we  = in_xfer && (command == c2d_pkg::CMD_LOAD_WGT) &&
                   (32'(flat_index) < WGT_DEPTH);
  assign bias_we = in_xfer && (command == c2d_pkg::CMD_LOAD_BIAS) &&
                   (32'(flat_index) < BIAS_DEPTH);

  c2d_ram #(.WIDTH(DW), .DEPTH(ACT_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (ACT_AW'(flat_index)),
    .wdata (load_value),
    .raddr (act_sum[ACT_AW-1:0]),
    .rdata (act_rdata)
  );

  c2d_ram #(.WIDTH(DW), .DEPTH(WGT_DEPTH)) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (WGT_AW'(flat_index)),
    .wdata (load_value),
    .raddr (widx[WGT_AW-1:0]),
    .rdata (wgt_rdata)
  );

  c2d_ram #(.WIDTH(DW), .DEPTH(BIAS_DEPTH)) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (BIAS_AW'(flat_index)),
    .wdata (load_value),
    .raddr (BIAS_AW'(co_q)),
    .rdata (bias_rdata)
  );

  // bias enters the MAC in the slot after the last tap, scaled by 2^FRACTION_BITS
  assign bias_go       = (state == S_DRAIN) && (dcnt == 2'd1) && bias_enable;
  assign mac_ctl.clear = (state == S_SETUP3);
  assign mac_ctl.en    = rd_ok || bias_go;
  assign mac_a         = bias_go ? $signed(bias_rdata) : $signed(act_rdata);
  assign mac_b         = bias_go ? BIAS_SCALE : $signed({wgt_rdata[DW-1], wgt_rdata});

  c2d_mac #(.ACC_W(ACC_W)) u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

endmodule

/* src/c2d_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/c2d_mac.sv */
// Shared multiply-accumulate unit: registered 16x17 signed product, then accumulate.
// Depends on c2d_pkg.
module c2d_mac #(
  parameter int ACC_W = 46
) (
  input  logic                              clk,
  input  logic                              rst,
  input  c2d_pkg::mac_ctl_t                 ctl,
  input  logic signed [c2d_pkg::DATA_W-1:0] a,
  input  logic signed [c2d_pkg::DATA_W:0]   b,
  output logic signed [ACC_W-1:0]           acc
);

  localparam int PROD_W = 2 * c2d_pkg::DATA_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc        <= '0;
    end else if (ctl.clear) begin
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      prod_valid <= ctl.en;
      if (prod_valid) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

endmodule
